@@ hw/rtl/cvsw_pkg.sv @@
// Shared types, record kind codes and body layout constants for the
// CodeView symbol record walker. No dependencies.
`default_nettype none

package cvsw_pkg;

  localparam logic [15:0] KIND_PUB32     = 16'h110E;
  localparam logic [15:0] KIND_GPROC32   = 16'h1110;
  localparam logic [15:0] KIND_LPROC32   = 16'h110F;
  localparam logic [15:0] KIND_GPROC_ID  = 16'h1147;
  localparam logic [15:0] KIND_LPROC_ID  = 16'h1146;

  localparam int PUB_MIN_BODY  = 11;
  localparam int PROC_MIN_BODY = 35;

  // Minimum record length (length covers the two kind bytes plus the body).
  localparam logic [15:0] PUB_MIN_LEN  = 16'(PUB_MIN_BODY + 2);
  localparam logic [15:0] PROC_MIN_LEN = 16'(PROC_MIN_BODY + 2);
  localparam logic [15:0] MIN_LEN      = 16'd2;

  // Body offsets of fields, per record class.
  localparam logic [15:0] PUB_FLAGS_AT  = 16'd0;
  localparam logic [15:0] PUB_OFF_AT    = 16'd4;
  localparam logic [15:0] PUB_SEG_AT    = 16'd8;
  localparam logic [15:0] PUB_NAME_AT   = 16'd10;
  localparam logic [15:0] PROC_OFF_AT   = 16'd24;
  localparam logic [15:0] PROC_SEG_AT   = 16'd28;
  localparam logic [15:0] PROC_NAME_AT  = 16'd31;

  localparam logic [16:0] HDR_LEN = 17'd4;

  localparam logic [1:0] RK_NAME = 2'd0;
  localparam logic [1:0] RK_DONE = 2'd1;
  localparam logic [1:0] RK_END  = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_PUB,
    CLS_PROC
  } cls_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  name_char;
    logic [31:0] sym_offset;
    logic [15:0] segment_number;
    logic        func_flag;
    logic [15:0] name_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       slot0;
    res_t       slot1;
  } push_t;

  function automatic logic is_proc_kind(input logic [15:0] k);
    is_proc_kind = (k == KIND_GPROC32) || (k == KIND_LPROC32) ||
                   (k == KIND_GPROC_ID) || (k == KIND_LPROC_ID);
  endfunction

  function automatic cls_t record_class(input logic [15:0] k, input logic [15:0] len);
    cls_t c;
    c = CLS_NONE;
    if (k == KIND_PUB32 && len >= PUB_MIN_LEN) begin
      c = CLS_PUB;
    end else if (is_proc_kind(k) && len >= PROC_MIN_LEN) begin
      c = CLS_PROC;
    end
    record_class = c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cvsw_ifs.sv @@
// Valid/ready channel interfaces for the symbol record walker:
// byte input channel and result channel. No dependencies.
`default_nettype none

interface cvsw_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface cvsw_out_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  name_char;
  logic [31:0] sym_offset;
  logic [15:0] segment_number;
  logic        func_flag;
  logic [15:0] name_length;
  logic        last;

  modport source (output valid, output result_kind, output name_char,
                  output sym_offset, output segment_number, output func_flag,
                  output name_length, output last, input ready);
  modport sink   (input valid, input result_kind, input name_char,
                  input sym_offset, input segment_number, input func_flag,
                  input name_length, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cvsw_parser.sv @@
// Record parser: per-byte field capture, position tracking and result
// generation (up to two results per byte). Depends on cvsw_pkg.
`default_nettype none

module cvsw_parser import cvsw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       stream_end,
  output push_t           push
);

  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic        fflag_r, fflag_nxt;
  logic [31:0] off_r, off_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [15:0] ncnt_r, ncnt_nxt;
  logic        nfin_r, nfin_nxt;
  logic        halted_r, halted_nxt;

  logic [15:0] len_w, kind_w, seg_w, ncnt_w;
  logic [31:0] off_w;
  logic        fflag_w, nfin_w;
  cls_t        cls;
  logic [15:0] q, off_at, seg_at, name_at;
  logic [1:0]  lane_off;
  logic        lane_seg;
  logic        name_emit, comp_emit, end_emit, fold, clear_rec;
  res_t        r_name, r_comp, r_end;

  always_comb begin
    len_w   = len_r;
    kind_w  = kind_r;
    fflag_w = fflag_r;
    off_w   = off_r;
    seg_w   = seg_r;
    ncnt_w  = ncnt_r;
    nfin_w  = nfin_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    name_emit  = 1'b0;
    comp_emit  = 1'b0;
    clear_rec  = 1'b0;
    q          = 16'(pos_r - HDR_LEN);
    lane_off   = '0;
    lane_seg   = 1'b0;

    if (step && !halted_r) begin
      priority if (pos_r == 17'd0) begin
        len_w = {8'h00, data_byte};
      end else if (pos_r == 17'd1) begin
        len_w = {data_byte, len_r[7:0]};
      end else if (pos_r == 17'd2) begin
        kind_w = {8'h00, data_byte};
      end else if (pos_r == 17'd3) begin
        kind_w = {data_byte, kind_r[7:0]};
      end else begin
      end
    end

    cls     = record_class(kind_w, len_w);
    off_at  = (cls == CLS_PROC) ? PROC_OFF_AT  : PUB_OFF_AT;
    seg_at  = (cls == CLS_PROC) ? PROC_SEG_AT  : PUB_SEG_AT;
    name_at = (cls == CLS_PROC) ? PROC_NAME_AT : PUB_NAME_AT;

    if (step && !halted_r && pos_r >= HDR_LEN && cls != CLS_NONE) begin
      lane_off = 2'(q - off_at);
      lane_seg = 1'(q - seg_at);
      if (cls == CLS_PUB && q == PUB_FLAGS_AT) begin
        fflag_w = data_byte[1];
      end
      if (q >= off_at && q < off_at + 16'd4) begin
        off_w[{lane_off, 3'b000} +: 8] = data_byte;
      end else if (q >= seg_at && q < seg_at + 16'd2) begin
        seg_w[{lane_seg, 3'b000} +: 8] = data_byte;
      end else if (q >= name_at && !nfin_r && seg_r != 16'd0) begin
        if (data_byte == 8'h00) begin
          nfin_w = 1'b1;
        end else begin
          name_emit = 1'b1;
          ncnt_w    = ncnt_r + 16'd1;
        end
      end
    end

    if (step && !halted_r) begin
      if (pos_r == 17'd1 && len_w < MIN_LEN) begin
        halted_nxt = 1'b1;
        clear_rec  = 1'b1;
      end else if (pos_r >= 17'd3 && pos_r == {1'b0, len_w} + 17'd1) begin
        comp_emit = (cls != CLS_NONE) && (seg_w != 16'd0) && (ncnt_w != 16'd0);
        clear_rec = 1'b1;
      end else begin
        pos_nxt = pos_r + 17'd1;
      end
    end

    fold     = stream_end && name_emit && comp_emit;
    end_emit = step && stream_end && !fold;

    if (step && stream_end) begin
      clear_rec  = 1'b1;
      halted_nxt = 1'b0;
    end

    if (clear_rec) begin
      pos_nxt   = '0;
      len_nxt   = '0;
      kind_nxt  = '0;
      fflag_nxt = 1'b0;
      off_nxt   = '0;
      seg_nxt   = '0;
      ncnt_nxt  = '0;
      nfin_nxt  = 1'b0;
    end else begin
      len_nxt   = len_w;
      kind_nxt  = kind_w;
      fflag_nxt = fflag_w;
      off_nxt   = off_w;
      seg_nxt   = seg_w;
      ncnt_nxt  = ncnt_w;
      nfin_nxt  = nfin_w;
    end

    r_name = '0;
    r_name.result_kind = RK_NAME;
    r_name.name_char   = data_byte;

    r_comp = '0;
    r_comp.result_kind    = RK_DONE;
    r_comp.sym_offset     = off_w;
    r_comp.segment_number = seg_w;
    r_comp.func_flag      = (cls == CLS_PROC) ? 1'b1 : fflag_w;
    r_comp.name_length    = ncnt_w;
    r_comp.last           = fold;

    r_end = '0;
    r_end.result_kind = RK_END;
    r_end.last        = 1'b1;

    push = '0;
    priority if (name_emit) begin
      push.slot0 = r_name;
      if (comp_emit) begin
        push.slot1 = r_comp;
        push.cnt   = 2'd2;
      end else if (end_emit) begin
        push.slot1 = r_end;
        push.cnt   = 2'd2;
      end else begin
        push.cnt   = 2'd1;
      end
    end else if (comp_emit) begin
      push.slot0 = r_comp;
      push.slot1 = r_end;
      push.cnt   = end_emit ? 2'd2 : 2'd1;
    end else if (end_emit) begin
      push.slot0 = r_end;
      push.cnt   = 2'd1;
    end else begin
      push.cnt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      kind_r   <= '0;
      fflag_r  <= 1'b0;
      off_r    <= '0;
      seg_r    <= '0;
      ncnt_r   <= '0;
      nfin_r   <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      kind_r   <= kind_nxt;
      fflag_r  <= fflag_nxt;
      off_r    <= off_nxt;
      seg_r    <= seg_nxt;
      ncnt_r   <= ncnt_nxt;
      nfin_r   <= nfin_nxt;
      halted_r <= halted_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && stream_end |=> pos_r == 17'd0 && !halted_r)
    else $error("stream end left parser state behind");

  a_end_yields: assert property (@(posedge clk) disable iff (!rst_n)
    step && stream_end |-> push.cnt != 2'd0)
    else $error("stream end produced no result");

  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> pos_r == 17'd0 && push.cnt <= 2'd1)
    else $error("halted parser still tracking a record");

endmodule

`default_nettype wire

@@ hw/rtl/cvsw_out_fifo.sv @@
// Result queue: takes up to two results per cycle from the parser and
// hands them out one per transfer. Depends on cvsw_pkg.
`default_nettype none

module cvsw_out_fifo import cvsw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       space,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_data
);

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];
  assign pop       = out_valid && out_ready;
  assign space     = (cnt_r <= QCNT_W'(QDEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + QPTR_W'(push.cnt);
    rp_nxt  = rp_r + QPTR_W'(pop);
    cnt_nxt = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.slot0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_r + QPTR_W'(1)] <= push.slot1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> space)
    else $error("push into a full result queue");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd0 && !pop |=> $stable(cnt_r) && $stable(rp_r))
    else $error("queue moved without a transfer");

endmodule

`default_nettype wire

@@ hw/rtl/codeview_symbol_record_walker.sv @@
// CodeView symbol record walker, top level.
// Depends on cvsw_pkg, cvsw_ifs, cvsw_parser and cvsw_out_fifo.
//
// in_ch carries the symbol stream one byte per transfer, stream_end set on
// the final byte. out_ch carries results: a name byte per emitted name
// character, a completion (offset, segment, function flag, name length) on
// the last byte of a qualifying record, and an end marker (last = 1) after
// the final byte; if the final byte both emits a name byte and completes a
// record, the completion carries last = 1 instead of a separate marker.
// A byte is held in an input register, parsed once the queue has room and
// its results written into a four-entry result queue; with the queue empty
// the first result shows on out_ch as soon as it is written into the queue.
// Throughput is one byte per cycle while the queue has room; a byte with two
// results needs two transfers on the result port, and the queue absorbs that.
// The parser advances only while the queue holds at most two results, so a
// run of two-result bytes can cost a bubble.
// When out_ch stalls, the queue fills, the input register holds its byte
// and in_ch.ready drops. Synchronous reset clears the parser state, the
// queue and the input valid bit; no clearing pass is needed.

`default_nettype none

module codeview_symbol_record_walker import cvsw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cvsw_in_if.sink    in_ch,
  cvsw_out_if.source out_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       space, step;
  push_t      push;
  res_t       out_data;

  assign step        = in_valid_r && space;
  assign in_ch.ready = !in_valid_r || space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
      in_end_r  <= in_ch.stream_end;
    end
  end

  cvsw_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_byte_r),
    .stream_end (in_end_r),
    .push       (push)
  );

  cvsw_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.result_kind    = out_data.result_kind;
  assign out_ch.name_char      = out_data.name_char;
  assign out_ch.sym_offset     = out_data.sym_offset;
  assign out_ch.segment_number = out_data.segment_number;
  assign out_ch.func_flag      = out_data.func_flag;
  assign out_ch.name_length    = out_data.name_length;
  assign out_ch.last           = out_data.last;

endmodule

`default_nettype wire

@@ dv/codeview_symbol_record_walker_test.sv @@
// Testbench for codeview_symbol_record_walker: random CodeView symbol streams
// against a cycle-free predictor of the emitted results. Uses cvsw_pkg and the
// channel interfaces from cvsw_ifs.
`default_nettype none

module codeview_symbol_record_walker_test;
  import cvsw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class symbol_result_board;
    res_t        pending_results[$];
    int          mismatch_count;
    int          rec_pos;
    logic [15:0] rec_len;
    logic [15:0] rec_kind;
    logic        fn_bit;
    logic [31:0] offset_acc;
    logic [15:0] segment_acc;
    logic [15:0] name_count;
    logic        name_done;
    logic        halted;

    function new();
      clear_record();
      halted = 1'b0;
      mismatch_count = 0;
    endfunction

    function void clear_record();
      rec_pos = 0;
      rec_len = '0;
      rec_kind = '0;
      fn_bit = 1'b0;
      offset_acc = '0;
      segment_acc = '0;
      name_count = '0;
      name_done = 1'b0;
    endfunction

    function cls_t record_flavor();
      int body;
      body = int'(rec_len) - 2;
      if (rec_kind == KIND_PUB32 && body >= PUB_MIN_BODY) return CLS_PUB;
      if ((rec_kind == KIND_GPROC32 || rec_kind == KIND_LPROC32 ||
           rec_kind == KIND_GPROC_ID || rec_kind == KIND_LPROC_ID) &&
          body >= PROC_MIN_BODY) return CLS_PROC;
      return CLS_NONE;
    endfunction

    function void push_result(logic [1:0] k, logic [7:0] ch, logic [31:0] off,
                              logic [15:0] seg, logic fn, logic [15:0] nlen,
                              logic fin);
      res_t r;
      r.result_kind = k;
      r.name_char = ch;
      r.sym_offset = off;
      r.segment_number = seg;
      r.func_flag = fn;
      r.name_length = nlen;
      r.last = fin;
      pending_results = {pending_results, r};
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      int   p;
      int   q;
      int   off_at;
      int   seg_at;
      int   name_at;
      cls_t c;
      logic name_out;
      logic folded;
      name_out = 1'b0;
      folded = 1'b0;
      if (!halted) begin
        p = rec_pos;
        case (p)
          0: rec_len = {8'h00, b};
          1: rec_len[15:8] = b;
          2: rec_kind = {8'h00, b};
          3: rec_kind[15:8] = b;
          default: begin
            q = p - 4;
            c = record_flavor();
            off_at = (c == CLS_PROC) ? int'(PROC_OFF_AT) : int'(PUB_OFF_AT);
            seg_at = (c == CLS_PROC) ? int'(PROC_SEG_AT) : int'(PUB_SEG_AT);
            name_at = (c == CLS_PROC) ? int'(PROC_NAME_AT) : int'(PUB_NAME_AT);
            if (c == CLS_PUB && q == 0) fn_bit = b[1];
            if (c != CLS_NONE) begin
              if (q >= off_at && q < off_at + 4) begin
                offset_acc |= 32'(b) << (8 * (q - off_at));
              end else if (q >= seg_at && q < seg_at + 2) begin
                segment_acc |= 16'(b) << (8 * (q - seg_at));
              end else if (q >= name_at && !name_done && segment_acc != 16'h0000) begin
                if (b == 8'h00) begin
                  name_done = 1'b1;
                end else begin
                  push_result(RK_NAME, b, '0, '0, 1'b0, '0, 1'b0);
                  name_count++;
                  name_out = 1'b1;
                end
              end
            end
          end
        endcase
        if (p == 1 && rec_len < MIN_LEN) begin
          halted = 1'b1;
          clear_record();
        end else if (p >= 3 && p == int'(rec_len) + 1) begin
          c = record_flavor();
          if (c != CLS_NONE && segment_acc != 16'h0000 && name_count != 16'h0000) begin
            folded = fin && name_out;
            push_result(RK_DONE, '0, offset_acc, segment_acc,
                        (c == CLS_PROC) ? 1'b1 : fn_bit, name_count, folded);
          end
          clear_record();
        end else begin
          rec_pos = p + 1;
        end
      end
      if (fin) begin
        if (!folded) push_result(RK_END, '0, '0, '0, 1'b0, '0, 1'b1);
        clear_record();
        halted = 1'b0;
      end
    endfunction

    function void compare_result(res_t got);
      res_t e;
      logic bad;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected: kind=%0d ch=%02h off=%08h seg=%04h fn=%0d len=%0d last=%0d",
                   got.result_kind, got.name_char, got.sym_offset,
                   got.segment_number, got.func_flag, got.name_length, got.last);
        return;
      end
      e = pending_results.pop_front();
      bad = (got.result_kind !== e.result_kind) || (got.name_char !== e.name_char) ||
            (got.sym_offset !== e.sym_offset) ||
            (got.segment_number !== e.segment_number) ||
            (got.func_flag !== e.func_flag) || (got.name_length !== e.name_length) ||
            (got.last !== e.last);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("exp: kind=%0d ch=%02h off=%08h seg=%04h fn=%0d len=%0d last=%0d",
                   e.result_kind, e.name_char, e.sym_offset, e.segment_number,
                   e.func_flag, e.name_length, e.last);
          $display("got: kind=%0d ch=%02h off=%08h seg=%04h fn=%0d len=%0d last=%0d",
                   got.result_kind, got.name_char, got.sym_offset,
                   got.segment_number, got.func_flag, got.name_length, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  int   hold_off_cycles;

  symbol_result_board sb = new();

  cvsw_in_if  in_ch ();
  cvsw_out_if out_ch ();

  codeview_symbol_record_walker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.result_kind = out_ch.result_kind;
      r.name_char = out_ch.name_char;
      r.sym_offset = out_ch.sym_offset;
      r.segment_number = out_ch.segment_number;
      r.func_flag = out_ch.func_flag;
      r.name_length = out_ch.name_length;
      r.last = out_ch.last;
      sb.compare_result(r);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.stream_end <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_byte(b, fin);
  endtask

  task automatic send_stream(ref logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
  endtask

  function automatic logic [15:0] pick_proc_kind();
    case ($urandom_range(0, 3))
      0: return KIND_GPROC32;
      1: return KIND_LPROC32;
      2: return KIND_GPROC_ID;
      default: return KIND_LPROC_ID;
    endcase
  endfunction

  // choice: 0 public, 1 procedure, 2 short body, 3 other kind, 4 short length
  function automatic void append_record(ref logic [7:0] s[$], input int choice,
                                        input int body_force);
    logic [15:0] len;
    logic [15:0] kind;
    logic [15:0] seg;
    logic [31:0] off;
    int          body;
    int          off_at;
    int          seg_at;
    int          name_at;
    int          nul_at;
    int          r;
    if (choice == 4) begin
      s = {s, 8'($urandom_range(0, 1))};
      s = {s, 8'h00};
      repeat ($urandom_range(0, 3)) s = {s, 8'($urandom_range(0, 255))};
      return;
    end
    off_at = int'(PUB_OFF_AT);
    seg_at = int'(PUB_SEG_AT);
    name_at = int'(PUB_NAME_AT);
    case (choice)
      0: begin
        kind = KIND_PUB32;
        body = PUB_MIN_BODY + int'($urandom_range(0, 8));
      end
      1: begin
        kind = pick_proc_kind();
        body = PROC_MIN_BODY + int'($urandom_range(0, 8));
        off_at = int'(PROC_OFF_AT);
        seg_at = int'(PROC_SEG_AT);
        name_at = int'(PROC_NAME_AT);
      end
      2: begin
        if ($urandom_range(0, 1)) begin
          kind = KIND_PUB32;
          body = int'($urandom_range(0, PUB_MIN_BODY - 1));
        end else begin
          kind = pick_proc_kind();
          body = int'($urandom_range(0, PROC_MIN_BODY - 1));
        end
      end
      default: begin
        kind = 16'($urandom_range(0, 65535));
        body = int'($urandom_range(0, 12));
      end
    endcase
    if (body_force >= 0) body = body_force;
    len = 16'(body + 2);
    s = {s, len[7:0]};
    s = {s, len[15:8]};
    s = {s, kind[7:0]};
    s = {s, kind[15:8]};
    if (choice > 1) begin
      repeat (body) s = {s, 8'($urandom_range(0, 255))};
      return;
    end
    r = int'($urandom_range(0, 9));
    seg = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'h0100 :
          16'($urandom_range(1, 65535));
    r = int'($urandom_range(0, 9));
    off = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    nul_at = body;
    if (body_force < 0 && $urandom_range(0, 3) == 0)
      nul_at = name_at + int'($urandom_range(0, body - name_at));
    for (int i = 0; i < body; i++) begin
      if (i >= off_at && i < off_at + 4) s = {s, off[8 * (i - off_at) +: 8]};
      else if (i >= seg_at && i < seg_at + 2) s = {s, seg[8 * (i - seg_at) +: 8]};
      else if (i >= name_at && i < nul_at) s = {s, 8'($urandom_range(1, 255))};
      else if (i == nul_at) s = {s, 8'h00};
      else s = {s, 8'($urandom_range(0, 255))};
    end
  endfunction

  function automatic void build_stream(ref logic [7:0] s[$]);
    logic [7:0] part[$];
    int         r;
    int         cut;
    repeat ($urandom_range(1, 4)) begin
      r = int'($urandom_range(0, 99));
      append_record(s, (r < 35) ? 0 : (r < 65) ? 1 : (r < 77) ? 2 : (r < 93) ? 3 : 4, -1);
    end
    // end the stream in the middle of a record
    if ($urandom_range(0, 3) == 0) begin
      append_record(part, int'($urandom_range(0, 1)), -1);
      cut = int'($urandom_range(1, part.size() - 1));
      for (int i = 0; i < cut; i++) s = {s, part[i]};
    end
  endfunction

  initial begin
    logic [7:0] s[$];
    int         sent;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.stream_end = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // public record whose last name byte also ends the stream
    s = {8'h0D, 8'h00, 8'h0E, 8'h11, 8'h02, 8'h00, 8'h00, 8'h00,
         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80};
    send_stream(s);
    // length below two halts parsing
    s = {8'h01, 8'h00, 8'h05};
    send_stream(s);
    s = {8'h7F};
    send_stream(s);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 53; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 53; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      if (ph == 0) hold_off_cycles = 80;
      sent = 0;
      while (sent < 90) begin
        s = {};
        build_stream(s);
        send_stream(s);
        sent += s.size();
      end
      if (ph == 0) begin
        // longest public record, cut short by stream end
        s = {8'hFF, 8'hFF, 8'h0E, 8'h11, 8'h02, 8'h00, 8'h00, 8'h00,
             8'h44, 8'h33, 8'h22, 8'h11, 8'h01, 8'h00, 8'h41, 8'h42};
        send_stream(s);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
